// ===== rtl/core/uti_pkg.sv =====
// Shared types and constants for the uniform-table linear interpolator.
// Used by every module under rtl/core; depends on nothing else.
package uti_pkg;

	localparam int TABLE_DEPTH   = 256;
	localparam int FRACTION_BITS = 16;

	localparam int VAL_W      = 32;
	localparam int CNT_W      = 9;
	localparam int LOAD_IDX_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int IDX_W      = $clog2(TABLE_DEPTH);
	localparam int NUM_W      = VAL_W + IDX_W;
	localparam int QUO_W      = IDX_W + FRACTION_BITS;

	localparam logic MODE_LOAD = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_COUNT = 2'd0,
		CFG_RANGE_START  = 2'd1,
		CFG_RANGE_END    = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REGION_BELOW  = 2'd0,
		REGION_INSIDE = 2'd1,
		REGION_ABOVE  = 2'd2
	} region_t;

	typedef struct packed {
		logic [IDX_W-1:0]        n_m1;
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		logic [VAL_W-1:0]        span;
	} cfg_t;

	typedef struct packed {
		logic                    valid;
		logic                    is_load;
		logic                    load_ok;
		logic [IDX_W-1:0]        load_idx;
		logic signed [VAL_W-1:0] load_value;
		region_t                 region;
	} tag_t;

endpackage

// ===== rtl/core/uti_front.sv =====
// Front end: range classification, offset from the lower bound and the
// scaling multiply by the sample count minus one. Depends on uti_pkg.
module uti_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             mode,
	input  logic [uti_pkg::LOAD_IDX_W-1:0]   sample_index,
	input  logic signed [uti_pkg::VAL_W-1:0] sample_value,
	input  logic signed [uti_pkg::VAL_W-1:0] x_value,
	input  uti_pkg::cfg_t                    cfg,
	output uti_pkg::tag_t                    tag_s2,
	output logic [uti_pkg::NUM_W-1:0]        num_s2
);

	uti_pkg::tag_t                tag_in;
	uti_pkg::tag_t                tag_s1;
	logic [uti_pkg::VAL_W:0]      diff_ext;
	logic [uti_pkg::VAL_W-1:0]    diff_s1;

	always_comb begin
		diff_ext = {x_value[uti_pkg::VAL_W-1], x_value} - {cfg.lo[uti_pkg::VAL_W-1], cfg.lo};
		tag_in.valid      = in_valid;
		tag_in.is_load    = (mode == uti_pkg::MODE_LOAD);
		tag_in.load_ok    = (32'(sample_index) < uti_pkg::TABLE_DEPTH);
		tag_in.load_idx   = uti_pkg::IDX_W'(sample_index);
		tag_in.load_value = sample_value;
		if (x_value <= cfg.lo) begin
			tag_in.region = uti_pkg::REGION_BELOW;
		end else if (x_value >= cfg.hi) begin
			tag_in.region = uti_pkg::REGION_ABOVE;
		end else begin
			tag_in.region = uti_pkg::REGION_INSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= diff_ext[uti_pkg::VAL_W-1:0];
		num_s2  <= uti_pkg::NUM_W'(diff_s1) * uti_pkg::NUM_W'(cfg.n_m1);
	end

endmodule

// ===== rtl/core/uti_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, giving the
// scaled table position with its fraction bits. Depends on uti_pkg.
module uti_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uti_pkg::tag_t                 tag_in,
	input  logic [uti_pkg::NUM_W-1:0]     num_in,
	input  logic [uti_pkg::VAL_W-1:0]     span,
	output uti_pkg::tag_t                 tag_out,
	output logic [uti_pkg::QUO_W-1:0]     quo_out
);

	uti_pkg::tag_t             tag_s [uti_pkg::QUO_W];
	logic [uti_pkg::VAL_W-1:0] rem_s [uti_pkg::QUO_W];
	logic [uti_pkg::QUO_W-1:0] quo_s [uti_pkg::QUO_W];
	logic [uti_pkg::IDX_W-1:0] low_s [uti_pkg::QUO_W];

	for (genvar j = 0; j < uti_pkg::QUO_W; j++) begin : g_step
		uti_pkg::tag_t             tag_prev;
		logic [uti_pkg::VAL_W-1:0] rem_prev;
		logic [uti_pkg::QUO_W-1:0] quo_prev;
		logic [uti_pkg::IDX_W-1:0] low_prev;
		logic [uti_pkg::VAL_W:0]   trial;
		logic                      take;

		if (j == 0) begin : g_first
			// The upper numerator bits are already below the divisor.
			assign tag_prev = tag_in;
			assign rem_prev = num_in[uti_pkg::NUM_W-1:uti_pkg::IDX_W];
			assign quo_prev = '0;
			assign low_prev = num_in[uti_pkg::IDX_W-1:0];
		end else begin : g_next
			assign tag_prev = tag_s[j-1];
			assign rem_prev = rem_s[j-1];
			assign quo_prev = quo_s[j-1];
			assign low_prev = low_s[j-1];
		end

		assign trial = {rem_prev, low_prev[uti_pkg::IDX_W-1]};
		assign take  = (trial >= {1'b0, span});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[j] <= '0;
			end else begin
				tag_s[j] <= tag_prev;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j] <= take ? uti_pkg::VAL_W'(trial - {1'b0, span}) : trial[uti_pkg::VAL_W-1:0];
			quo_s[j] <= (quo_prev << 1) | uti_pkg::QUO_W'(take);
			low_s[j] <= low_prev << 1;
		end
	end

	assign tag_out = tag_s[uti_pkg::QUO_W-1];
	assign quo_out = quo_s[uti_pkg::QUO_W-1];

endmodule

// ===== rtl/core/uti_table.sv =====
// Sample memory with one write and two registered reads; selects the
// neighboring entries for a query and applies loads in order. Depends on uti_pkg.
module uti_table (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  uti_pkg::tag_t                          tag_in,
	input  logic [uti_pkg::QUO_W-1:0]              quo_in,
	input  logic [uti_pkg::IDX_W-1:0]              n_m1,
	output uti_pkg::tag_t                          tag_s1,
	output logic signed [uti_pkg::VAL_W-1:0]       first_s1,
	output logic signed [uti_pkg::VAL_W-1:0]       second_s1,
	output logic [uti_pkg::FRACTION_BITS-1:0]      frac_s1
);

	logic signed [uti_pkg::VAL_W-1:0]  mem [uti_pkg::TABLE_DEPTH];
	logic [uti_pkg::IDX_W-1:0]         ipart;
	logic [uti_pkg::IDX_W-1:0]         addr_a;
	logic [uti_pkg::IDX_W-1:0]         addr_b;
	logic [uti_pkg::FRACTION_BITS-1:0] frac;

	always_comb begin
		ipart  = quo_in[uti_pkg::QUO_W-1:uti_pkg::FRACTION_BITS];
		addr_a = '0;
		addr_b = '0;
		frac   = '0;
		unique case (tag_in.region)
			uti_pkg::REGION_BELOW: begin
				addr_a = '0;
			end
			uti_pkg::REGION_ABOVE: begin
				addr_a = n_m1;
				addr_b = n_m1;
			end
			uti_pkg::REGION_INSIDE: begin
				addr_a = (ipart > n_m1) ? n_m1 : ipart;
				addr_b = (addr_a == n_m1) ? n_m1 : addr_a + 1'b1;
				frac   = quo_in[uti_pkg::FRACTION_BITS-1:0];
			end
			default: begin
				addr_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_in.valid && tag_in.is_load && tag_in.load_ok) begin
			mem[tag_in.load_idx] <= tag_in.load_value;
		end
		first_s1  <= mem[addr_a];
		second_s1 <= mem[addr_b];
		frac_s1   <= frac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_in;
		end
	end

endmodule

// ===== rtl/core/uti_blend.sv =====
// Blend of the two neighboring samples: slope times fraction, floor
// scaling, add and saturation to 32 bits. Depends on uti_pkg.
module uti_blend (
	input  logic                              clk,
	input  logic                              arst_n,
	input  uti_pkg::tag_t                     tag_in,
	input  logic signed [uti_pkg::VAL_W-1:0]  first_in,
	input  logic signed [uti_pkg::VAL_W-1:0]  second_in,
	input  logic [uti_pkg::FRACTION_BITS-1:0] frac_in,
	output logic                              done_s2,
	output logic signed [uti_pkg::VAL_W-1:0]  y_s2,
	output logic [1:0]                        region_s2
);

	localparam int PROD_W = uti_pkg::VAL_W + uti_pkg::FRACTION_BITS + 2;
	localparam int Q_W    = PROD_W - uti_pkg::FRACTION_BITS;
	localparam int SUM_W  = Q_W + 1;
	localparam logic signed [uti_pkg::VAL_W-1:0] VAL_MAX = {1'b0, {(uti_pkg::VAL_W-1){1'b1}}};
	localparam logic signed [uti_pkg::VAL_W-1:0] VAL_MIN = {1'b1, {(uti_pkg::VAL_W-1){1'b0}}};

	uti_pkg::tag_t                      tag_s1;
	logic signed [uti_pkg::VAL_W:0]     diff;
	logic signed [uti_pkg::FRACTION_BITS:0] frac_sx;
	logic signed [PROD_W-1:0]           prod_s1;
	logic signed [uti_pkg::VAL_W-1:0]   first_s1;
	logic signed [Q_W-1:0]              q;
	logic signed [SUM_W-1:0]            sum;
	logic signed [uti_pkg::VAL_W-1:0]   y_sat;

	always_comb begin
		diff    = {second_in[uti_pkg::VAL_W-1], second_in} - {first_in[uti_pkg::VAL_W-1], first_in};
		frac_sx = {1'b0, frac_in};
	end

	always_ff @(posedge clk) begin
		prod_s1  <= diff * frac_sx;
		first_s1 <= first_in;
	end

	// Dropping the fraction bits of a two's complement product rounds toward minus infinity.
	always_comb begin
		q   = prod_s1[PROD_W-1:uti_pkg::FRACTION_BITS];
		sum = SUM_W'(first_s1) + SUM_W'(q);
		if (sum > SUM_W'(VAL_MAX)) begin
			y_sat = VAL_MAX;
		end else if (sum < SUM_W'(VAL_MIN)) begin
			y_sat = VAL_MIN;
		end else begin
			y_sat = sum[uti_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1  <= '0;
			done_s2 <= 1'b0;
		end else begin
			tag_s1  <= tag_in;
			done_s2 <= tag_s1.valid && !tag_s1.is_load;
		end
	end

	always_ff @(posedge clk) begin
		y_s2      <= y_sat;
		region_s2 <= tag_s1.region;
	end

endmodule

// ===== rtl/core/uniform_table_linear_interp.sv =====
// Linear interpolation in a table of evenly spaced samples, fully pipelined.
// A word is taken in every cycle; busy stays low. A query's result is on the
// outputs, with done high, once it has passed the front end, the divider (one
// quotient bit per stage), the table read and the blend. Loads give no result.
// Reset clears the pipeline valid bits and loads the default settings;
// the table itself holds nothing defined until written.
module uniform_table_linear_interp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 mode,
	input  logic [uti_pkg::LOAD_IDX_W-1:0]       sample_index,
	input  logic signed [uti_pkg::VAL_W-1:0]     sample_value,
	input  logic signed [uti_pkg::VAL_W-1:0]     x_value,
	input  logic                                 cfg_wr_en,
	input  logic [uti_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [uti_pkg::VAL_W-1:0]            cfg_wdata,
	output logic                                 done,
	output logic signed [uti_pkg::VAL_W-1:0]     y_value,
	output logic [1:0]                           region
);

	logic [uti_pkg::CNT_W-1:0]        sample_count_q;
	logic signed [uti_pkg::VAL_W-1:0] range_start_q;
	logic signed [uti_pkg::VAL_W-1:0] range_end_q;
	logic [uti_pkg::VAL_W:0]          span_ext;
	uti_pkg::cfg_t                    cfg;

	uti_pkg::tag_t                      front_tag;
	logic [uti_pkg::NUM_W-1:0]          front_num;
	uti_pkg::tag_t                      div_tag;
	logic [uti_pkg::QUO_W-1:0]          div_quo;
	uti_pkg::tag_t                      tbl_tag;
	logic signed [uti_pkg::VAL_W-1:0]   tbl_first;
	logic signed [uti_pkg::VAL_W-1:0]   tbl_second;
	logic [uti_pkg::FRACTION_BITS-1:0]  tbl_frac;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= uti_pkg::CNT_W'(1);
			range_start_q  <= '0;
			range_end_q    <= uti_pkg::VAL_W'(65536);
		end else if (cfg_wr_en) begin
			unique case (uti_pkg::cfg_idx_t'(cfg_addr))
				uti_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_wdata[uti_pkg::CNT_W-1:0];
				uti_pkg::CFG_RANGE_START:  range_start_q  <= cfg_wdata;
				uti_pkg::CFG_RANGE_END:    range_end_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (sample_count_q == '0) begin
			cfg.n_m1 = '0;
		end else if (32'(sample_count_q) > uti_pkg::TABLE_DEPTH) begin
			cfg.n_m1 = uti_pkg::IDX_W'(uti_pkg::TABLE_DEPTH - 1);
		end else begin
			cfg.n_m1 = uti_pkg::IDX_W'(sample_count_q - 1'b1);
		end
		if (range_start_q < range_end_q) begin
			cfg.lo = range_start_q;
			cfg.hi = range_end_q;
		end else begin
			cfg.lo = range_end_q;
			cfg.hi = range_start_q;
		end
		span_ext = {cfg.hi[uti_pkg::VAL_W-1], cfg.hi} - {cfg.lo[uti_pkg::VAL_W-1], cfg.lo};
		cfg.span = span_ext[uti_pkg::VAL_W-1:0];
	end

	uti_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start && !busy),
		.mode         (mode),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.x_value      (x_value),
		.cfg          (cfg),
		.tag_s2       (front_tag),
		.num_s2       (front_num)
	);

	uti_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (front_tag),
		.num_in  (front_num),
		.span    (cfg.span),
		.tag_out (div_tag),
		.quo_out (div_quo)
	);

	uti_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (div_tag),
		.quo_in    (div_quo),
		.n_m1      (cfg.n_m1),
		.tag_s1    (tbl_tag),
		.first_s1  (tbl_first),
		.second_s1 (tbl_second),
		.frac_s1   (tbl_frac)
	);

	uti_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tbl_tag),
		.first_in  (tbl_first),
		.second_in (tbl_second),
		.frac_in   (tbl_frac),
		.done_s2   (done),
		.y_s2      (y_value),
		.region_s2 (region)
	);

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for uniform_table_linear_interp: loads samples, queries positions
// and compares every result with a predictor kept in a small scoreboard class.
// Depends on uti_pkg and the block's top level only.
`timescale 1ns / 1ps

module tb;

	localparam logic MODE_QUERY = ~uti_pkg::MODE_LOAD;
	localparam logic [uti_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [uti_pkg::VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam int DRAIN_CYCLES = 32;

	typedef struct {
		logic signed [uti_pkg::VAL_W-1:0] y;
		uti_pkg::region_t                 area;
	} point_t;

	class interp_checker;
		logic signed [uti_pkg::VAL_W-1:0] samples [uti_pkg::TABLE_DEPTH];
		logic [uti_pkg::CNT_W-1:0]        count_reg;
		logic signed [uti_pkg::VAL_W-1:0] start_reg;
		logic signed [uti_pkg::VAL_W-1:0] end_reg;
		point_t                           expected_points [$];
		int                               errors;

		function new();
			count_reg = uti_pkg::CNT_W'(1);
			start_reg = '0;
			end_reg   = 32'sd65536;
			errors    = 0;
		endfunction

		task report_mismatch(string msg);
			if (errors < 100)
				$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_reg(uti_pkg::cfg_idx_t idx, logic [uti_pkg::VAL_W-1:0] data);
			case (idx)
			uti_pkg::CFG_SAMPLE_COUNT: count_reg = data[uti_pkg::CNT_W-1:0];
			uti_pkg::CFG_RANGE_START:  start_reg = data;
			uti_pkg::CFG_RANGE_END:    end_reg   = data;
			default: ;
			endcase
		endfunction

		function point_t interpolate(logic signed [uti_pkg::VAL_W-1:0] x_in);
			longint n, lo, hi, x, span, num, whole, rem, frac, left, right, y;
			int i0, i1;
			point_t pt;
			n = longint'(count_reg);
			if (n == 0) n = 1;
			if (n > uti_pkg::TABLE_DEPTH) n = uti_pkg::TABLE_DEPTH;
			lo = (start_reg < end_reg) ? start_reg : end_reg;
			hi = (start_reg > end_reg) ? start_reg : end_reg;
			x = x_in;
			if (x <= lo) begin
				y = samples[0];
				pt.area = uti_pkg::REGION_BELOW;
			end else if (x >= hi) begin
				y = samples[n-1];
				pt.area = uti_pkg::REGION_ABOVE;
			end else begin
				span  = hi - lo;
				num   = (x - lo) * (n - 1);
				whole = num / span;
				rem   = num % span;
				frac  = (rem << uti_pkg::FRACTION_BITS) / span;
				if (whole > n - 1) whole = n - 1;
				i0 = int'(whole);
				i1 = (i0 + 1 > n - 1) ? int'(n - 1) : i0 + 1;
				left  = samples[i0];
				right = samples[i1];
				y = left + (((right - left) * frac) >>> uti_pkg::FRACTION_BITS);
				pt.area = uti_pkg::REGION_INSIDE;
			end
			if (y > 64'sd2147483647) y = 64'sd2147483647;
			if (y < -64'sd2147483648) y = -64'sd2147483648;
			pt.y = y[uti_pkg::VAL_W-1:0];
			return pt;
		endfunction

		function void note_word(logic m, logic [uti_pkg::LOAD_IDX_W-1:0] idx,
				logic signed [uti_pkg::VAL_W-1:0] sval, logic signed [uti_pkg::VAL_W-1:0] x);
			if (m == uti_pkg::MODE_LOAD)
				samples[idx] = sval;
			else
				expected_points.push_back(interpolate(x));
		endfunction

		task check_result(logic signed [uti_pkg::VAL_W-1:0] y, logic [1:0] area);
			point_t pt;
			if (expected_points.size() == 0) begin
				report_mismatch($sformatf("result y=%h region=%0d with no query waiting",
					y, area));
			end else begin
				pt = expected_points.pop_front();
				if (y !== pt.y)
					report_mismatch($sformatf("y_value %h, expected %h", y, pt.y));
				if (area !== pt.area)
					report_mismatch($sformatf("region %0d, expected %0d", area, pt.area));
			end
		endtask
	endclass

	logic                             clk;
	logic                             arst_n;
	logic                             start;
	logic                             busy;
	logic                             mode;
	logic [uti_pkg::LOAD_IDX_W-1:0]   sample_index;
	logic signed [uti_pkg::VAL_W-1:0] sample_value;
	logic signed [uti_pkg::VAL_W-1:0] x_value;
	logic                             cfg_wr_en;
	logic [uti_pkg::CFG_IDX_W-1:0]    cfg_addr;
	logic [uti_pkg::VAL_W-1:0]        cfg_wdata;
	logic                             done;
	logic signed [uti_pkg::VAL_W-1:0] y_value;
	logic [1:0]                       region;

	interp_checker sb;
	int            idle_pct;

	uniform_table_linear_interp i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.x_value      (x_value),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.y_value      (y_value),
		.region       (region)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(y_value, region);
	end

	task automatic send_word(input logic m, input logic [uti_pkg::LOAD_IDX_W-1:0] idx,
			input logic [uti_pkg::VAL_W-1:0] sval, input logic [uti_pkg::VAL_W-1:0] x);
		while ($urandom_range(99) < idle_pct) begin
			start        <= 1'b0;
			mode         <= 1'($urandom_range(1));
			sample_index <= uti_pkg::LOAD_IDX_W'($urandom_range(255));
			sample_value <= $urandom;
			x_value      <= $urandom;
			@(posedge clk);
		end
		start        <= 1'b1;
		mode         <= m;
		sample_index <= idx;
		sample_value <= sval;
		x_value      <= x;
		do @(posedge clk); while (busy);
		sb.note_word(m, idx, sval, x);
	endtask

	task automatic send_query(input logic [uti_pkg::VAL_W-1:0] x);
		send_word(MODE_QUERY, uti_pkg::LOAD_IDX_W'($urandom_range(255)), $urandom, x);
	endtask

	task automatic send_load(input logic [uti_pkg::LOAD_IDX_W-1:0] idx,
			input logic [uti_pkg::VAL_W-1:0] v);
		send_word(uti_pkg::MODE_LOAD, idx, v, $urandom);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (sb.expected_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_config(input logic [uti_pkg::CNT_W-1:0] count,
			input logic [uti_pkg::VAL_W-1:0] rs, input logic [uti_pkg::VAL_W-1:0] re);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= uti_pkg::CFG_SAMPLE_COUNT;
		cfg_wdata <= uti_pkg::VAL_W'(count);
		@(posedge clk);
		sb.set_reg(uti_pkg::CFG_SAMPLE_COUNT, uti_pkg::VAL_W'(count));
		cfg_addr  <= uti_pkg::CFG_RANGE_START;
		cfg_wdata <= rs;
		@(posedge clk);
		sb.set_reg(uti_pkg::CFG_RANGE_START, rs);
		cfg_addr  <= uti_pkg::CFG_RANGE_END;
		cfg_wdata <= re;
		@(posedge clk);
		sb.set_reg(uti_pkg::CFG_RANGE_END, re);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_config();
		logic [uti_pkg::CNT_W-1:0] count;
		logic [uti_pkg::VAL_W-1:0] rs, re;
		case ($urandom_range(7))
		0: count = '0;
		1: count = uti_pkg::CNT_W'(1);
		2: count = uti_pkg::CNT_W'(2);
		3: count = uti_pkg::CNT_W'(uti_pkg::TABLE_DEPTH);
		4: count = uti_pkg::CNT_W'($urandom_range(511, uti_pkg::TABLE_DEPTH + 1));
		5: count = uti_pkg::CNT_W'(511);
		default: count = uti_pkg::CNT_W'($urandom_range(uti_pkg::TABLE_DEPTH, 1));
		endcase
		rs = $urandom;
		case ($urandom_range(5))
		0: begin
			rs = $urandom_range(1) ? VAL_MIN : VAL_MAX;
			re = ~rs;
		end
		1: re = rs;
		2: re = rs + $urandom_range(300);
		3: begin
			rs = $urandom_range(32'h0010_0000) - 32'h0008_0000;
			re = $urandom_range(32'h0010_0000) - 32'h0008_0000;
		end
		default: re = $urandom;
		endcase
		apply_config(count, rs, re);
	endtask

	function automatic logic [uti_pkg::VAL_W-1:0] pick_position();
		longint lo, hi, pos;
		int unsigned span;
		lo = (sb.start_reg < sb.end_reg) ? sb.start_reg : sb.end_reg;
		hi = (sb.start_reg > sb.end_reg) ? sb.start_reg : sb.end_reg;
		span = 32'(hi - lo);
		case ($urandom_range(7))
		0: pos = $urandom;
		1: pos = lo + $urandom_range(2) - 1;
		2: pos = hi + $urandom_range(2) - 1;
		default: pos = lo + longint'($urandom_range(span, 0));
		endcase
		return pos[uti_pkg::VAL_W-1:0];
	endfunction

	function automatic logic [uti_pkg::VAL_W-1:0] pick_sample();
		case ($urandom_range(15))
		0: return VAL_MIN;
		1: return VAL_MAX;
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	initial begin
		sb = new();
		idle_pct = 0;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		mode         <= uti_pkg::MODE_LOAD;
		sample_index <= '0;
		sample_value <= '0;
		x_value      <= '0;
		cfg_wr_en    <= 1'b0;
		cfg_addr     <= uti_pkg::CFG_SAMPLE_COUNT;
		cfg_wdata    <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one sample over 0.0 .. 1.0.
		send_load('0, VAL_MAX);
		send_query(VAL_MIN);
		send_query('0);
		send_query(32'sd32768);
		send_query(32'sd65536);
		send_query(VAL_MAX);

		for (int i = 0; i < uti_pkg::TABLE_DEPTH; i++)
			send_load(uti_pkg::LOAD_IDX_W'(i),
				(i == 0) ? VAL_MIN : (i == 1) ? VAL_MAX : $urandom);
		send_load(uti_pkg::LOAD_IDX_W'(255), VAL_MIN);
		send_query(32'sd1);

		wait_idle();
		apply_config(uti_pkg::CNT_W'(2), VAL_MIN, VAL_MAX);
		send_query(VAL_MIN + 32'd1);
		send_query('1);
		send_query('0);
		send_query(VAL_MAX - 32'd1);
		send_query(VAL_MAX);

		wait_idle();
		apply_config('0, 32'sd262144, -32'sd262144);
		send_query(-32'sd262144);
		send_query(-32'sd1000);
		send_query(32'sd262143);

		wait_idle();
		apply_config(uti_pkg::CNT_W'(511), '0, '0);
		send_query('1);
		send_query('0);
		send_query(32'sd1);

		wait_idle();
		apply_config(uti_pkg::CNT_W'(uti_pkg::TABLE_DEPTH), VAL_MAX, VAL_MIN);
		send_query(32'sd12345678);
		send_query(VAL_MAX - 32'd1);

		for (int seg = 0; seg < 16; seg++) begin
			wait_idle();
			random_config();
			idle_pct = (seg < 6) ? 38 : (seg < 11) ? 77 : 0;
			for (int k = 0; k < 83; k++) begin
				if ($urandom_range(9) < 7)
					send_query(pick_position());
				else
					send_load(uti_pkg::LOAD_IDX_W'($urandom_range(255)), pick_sample());
			end
		end

		idle_pct = 0;
		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
